>>> design/vcf_pkg.sv
// ----------------------------------------------------------------------------
// vcf_pkg
// Shared types and constants of the 3x3 video convolution filter.
// ----------------------------------------------------------------------------
`default_nettype none

package vcf_pkg;

    // input word of one clock of video
    typedef struct packed {
        logic       line_valid;
        logic       frame_valid;
        logic [7:0] pixel_in;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [7:0] pixel_out;
        logic       line_valid_out;
        logic       frame_valid_out;
    } out_word_t;

    // coefficient rows, column 0 in the low byte
    typedef struct packed {
        logic [23:0] row_c;
        logic [23:0] row_b;
        logic [23:0] row_a;
    } coef_bank_t;

    // register indexes
    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;

    // accumulator and divider sizes
    localparam int ACC_W  = 20;
    localparam int MAG_W  = 19;
    localparam int NORM_W = 11;
    localparam int CNT_W  = 5;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RD    = 6'b000100,
        ST_MAC   = 6'b001000,
        ST_DIVS  = 6'b010000,
        ST_DIV   = 6'b100000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic mac;
        logic div_start;
        logic div_step;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic conv_needed;
        logic tap_last;
        logic div_last;
        logic out_free;
    } sts_t;

    // kernel row for store row i given the physical line
    function automatic logic [1:0] kernel_row(input logic [1:0] i, input logic [1:0] phys);
        logic [2:0] s;
        s = 3'(i) + 3'd5 - 3'(phys);
        kernel_row = (s >= 3'd6) ? 2'(s - 3'd6) : (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/video_3x3_convolution_filter.sv
// throughput: one word at a time; a filtered word walks nine taps through the
// single line store read port and then a 19-step serial divider
// reset: asynchronous, active low; afterwards the line store is swept to zero
// before the first word is taken
// ----------------------------------------------------------------------------
// video_3x3_convolution_filter
// 3x3 weighted filter over a three-line ring store with normalising division.
// ----------------------------------------------------------------------------
`default_nettype none

module video_3x3_convolution_filter #(
    parameter int LINE_WIDTH = 720
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire vcf_pkg::in_word_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output vcf_pkg::out_word_t       out_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    vcf_pkg::coef_bank_t coefs;
    vcf_pkg::cmd_t       cmd;
    vcf_pkg::sts_t       sts;

    vcf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    vcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vcf_datapath #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .coefs     (coefs),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

`default_nettype wire

>>> design/vcf_regs.sv
// ----------------------------------------------------------------------------
// vcf_regs
// Coefficient register bank behind the APB-style configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module vcf_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output vcf_pkg::coef_bank_t     coefs
);

    vcf_pkg::coef_bank_t coef_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign coefs  = coef_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                vcf_pkg::REG_COEF_A: coef_reg.row_a <= pwdata[23:0];
                vcf_pkg::REG_COEF_B: coef_reg.row_b <= pwdata[23:0];
                vcf_pkg::REG_COEF_C: coef_reg.row_c <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[3:2])
            vcf_pkg::REG_COEF_A: prdata = {8'd0, coef_reg.row_a};
            vcf_pkg::REG_COEF_B: prdata = {8'd0, coef_reg.row_b};
            vcf_pkg::REG_COEF_C: prdata = {8'd0, coef_reg.row_c};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/vcf_ctrl.sv
// ----------------------------------------------------------------------------
// vcf_ctrl
// Sequencer: store clearing, tap walk, division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module vcf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire vcf_pkg::sts_t sts,
    output vcf_pkg::cmd_t      cmd
);

    vcf_pkg::state_t state_reg, state_next;
    logic            done_pending_reg, done_pending_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= vcf_pkg::ST_CLEAR;
            done_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            done_pending_reg <= done_pending_next;
        end
    end

    // a finished word waits in done_pending until the output slot is free
    always_comb
    begin
        state_next        = state_reg;
        done_pending_next = done_pending_reg;
        cmd               = '0;
        in_ready          = 1'b0;
        if (done_pending_reg && sts.out_free)
        begin
            cmd.load          = 1'b1;
            done_pending_next = 1'b0;
        end
        case (state_reg)
            vcf_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_done)
                    state_next = vcf_pkg::ST_IDLE;
            end
            vcf_pkg::ST_IDLE:
            begin
                in_ready = !done_pending_reg;
                if (in_valid && !done_pending_reg)
                begin
                    cmd.accept = 1'b1;
                    if (sts.conv_needed)
                        state_next = vcf_pkg::ST_RD;
                    else
                        done_pending_next = 1'b1;
                end
            end
            vcf_pkg::ST_RD:
            begin
                state_next = vcf_pkg::ST_MAC;
            end
            vcf_pkg::ST_MAC:
            begin
                cmd.mac    = 1'b1;
                state_next = sts.tap_last ? vcf_pkg::ST_DIVS : vcf_pkg::ST_RD;
            end
            vcf_pkg::ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = vcf_pkg::ST_DIV;
            end
            vcf_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    done_pending_next = 1'b1;
                    state_next        = vcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vcf_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/vcf_datapath.sv
// ----------------------------------------------------------------------------
// vcf_datapath
// Line store, position counters, tap multiply-accumulate and serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module vcf_datapath #(
    parameter int LINE_WIDTH = 720
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vcf_pkg::in_word_t   in_data,
    input  wire vcf_pkg::coef_bank_t coefs,
    input  wire vcf_pkg::cmd_t       cmd,
    output vcf_pkg::sts_t            sts,
    output vcf_pkg::out_word_t       out_data,
    output logic                     out_valid,
    input  wire logic                out_ready
);

    localparam int STORE = 3 * LINE_WIDTH;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(LINE_WIDTH);
    localparam int DW    = $clog2(LINE_WIDTH + 2);

    logic [7:0]               mem [STORE];
    logic [7:0]               rd_reg;
    logic [AW-1:0]            clr_reg, pos_reg;
    logic [CW-1:0]            col_reg;
    logic [1:0]               phys_reg, ti_reg, tj_reg;
    logic [DW-1:0]            delay_reg;
    logic                     conv_reg, lv_reg, fv_reg, neg_reg;
    logic signed [vcf_pkg::ACC_W-1:0]  acc_reg;
    logic [vcf_pkg::NORM_W-1:0]        norm_reg;
    logic [vcf_pkg::MAG_W-1:0]         mag_reg;
    logic [vcf_pkg::NORM_W-1:0]        rem_reg;
    logic [vcf_pkg::CNT_W-1:0]         cnt_reg;
    logic [7:0]               held_pixel_reg;
    logic                     held_lv_reg, held_fv_reg, out_valid_reg;

    logic                     we;
    logic [AW-1:0]            wa, ra, base;
    logic [7:0]               wd;
    logic                     tap_ok;
    logic [23:0]              row_sel;
    logic [1:0]               kcol;
    logic signed [7:0]        w;
    logic signed [16:0]       prod;
    logic [7:0]               w_abs;
    logic [vcf_pkg::NORM_W:0] trial;
    logic [vcf_pkg::ACC_W-1:0] acc_abs;
    logic [7:0]               q8, res;

    // status
    assign sts.clr_done    = (clr_reg == AW'(STORE - 1));
    assign sts.conv_needed = in_data.line_valid && (delay_reg == '0);
    assign sts.tap_last    = (ti_reg == 2'd2) && (tj_reg == 2'd2);
    assign sts.div_last    = (cnt_reg == vcf_pkg::CNT_W'(vcf_pkg::MAG_W - 1));
    assign sts.out_free    = !out_valid_reg || out_ready;

    // store write port: clearing sweep or incoming pixel
    assign we = cmd.clear || (cmd.accept && in_data.line_valid);
    assign wa = cmd.clear ? clr_reg : pos_reg;
    assign wd = cmd.clear ? 8'd0 : in_data.pixel_in;

    // tap address
    always_comb
    begin
        case (ti_reg)
            2'd1:    base = AW'(LINE_WIDTH);
            2'd2:    base = AW'(2 * LINE_WIDTH);
            default: base = '0;
        endcase
        tap_ok = (col_reg >= CW'(tj_reg));
        ra     = tap_ok ? AW'(base + AW'(col_reg) - AW'(tj_reg)) : base;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_reg <= mem[ra];
    end

    // weight of the current tap
    always_comb
    begin
        case (vcf_pkg::kernel_row(ti_reg, phys_reg))
            2'd0:    row_sel = coefs.row_a;
            2'd1:    row_sel = coefs.row_b;
            default: row_sel = coefs.row_c;
        endcase
        kcol = 2'd2 - tj_reg;
        case (kcol)
            2'd0:    w = $signed(row_sel[7:0]);
            2'd1:    w = $signed(row_sel[15:8]);
            default: w = $signed(row_sel[23:16]);
        endcase
        w_abs = w[7] ? 8'(-w) : 8'(w);
        prod  = $signed({9'd0, rd_reg}) * 17'(w);
    end

    // divider step and result
    assign trial   = {rem_reg, mag_reg[vcf_pkg::MAG_W-1]};
    assign acc_abs = acc_reg[vcf_pkg::ACC_W-1] ? vcf_pkg::ACC_W'(-acc_reg)
                                               : vcf_pkg::ACC_W'(acc_reg);
    assign q8      = neg_reg ? 8'(-mag_reg[7:0]) : mag_reg[7:0];
    assign res     = (norm_reg == '0) ? acc_reg[7:0] : q8;

    // clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear && !sts.clr_done)
            clr_reg <= clr_reg + 1'b1;
    end

    // position and start delay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            col_reg   <= '0;
            phys_reg  <= '0;
            delay_reg <= DW'(LINE_WIDTH + 1);
        end
        else if (cmd.accept && in_data.line_valid)
        begin
            if (pos_reg == AW'(STORE - 1))
                pos_reg <= '0;
            else
                pos_reg <= pos_reg + 1'b1;
            if (col_reg == CW'(LINE_WIDTH - 1))
            begin
                col_reg  <= '0;
                phys_reg <= (phys_reg == 2'd2) ? 2'd0 : phys_reg + 2'd1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
            if (delay_reg != '0)
                delay_reg <= delay_reg - 1'b1;
        end
    end

    // word capture, tap walk and division
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_reg <= 1'b0;
            lv_reg   <= 1'b0;
            fv_reg   <= 1'b0;
            ti_reg   <= '0;
            tj_reg   <= '0;
            acc_reg  <= '0;
            norm_reg <= '0;
            neg_reg  <= 1'b0;
            mag_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                conv_reg <= sts.conv_needed;
                lv_reg   <= in_data.line_valid;
                fv_reg   <= in_data.frame_valid;
                ti_reg   <= '0;
                tj_reg   <= '0;
                acc_reg  <= '0;
                norm_reg <= '0;
            end
            if (cmd.mac)
            begin
                if (tap_ok)
                begin
                    acc_reg  <= acc_reg + vcf_pkg::ACC_W'(prod);
                    norm_reg <= norm_reg + vcf_pkg::NORM_W'(w_abs);
                end
                if (tj_reg == 2'd2)
                begin
                    tj_reg <= '0;
                    ti_reg <= ti_reg + 2'd1;
                end
                else
                begin
                    tj_reg <= tj_reg + 2'd1;
                end
            end
            if (cmd.div_start)
            begin
                neg_reg <= acc_reg[vcf_pkg::ACC_W-1];
                mag_reg <= acc_abs[vcf_pkg::MAG_W-1:0];
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (trial >= {1'b0, norm_reg})
                begin
                    rem_reg <= vcf_pkg::NORM_W'(trial - {1'b0, norm_reg});
                    mag_reg <= {mag_reg[vcf_pkg::MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[vcf_pkg::NORM_W-1:0];
                    mag_reg <= {mag_reg[vcf_pkg::MAG_W-2:0], 1'b0};
                end
            end
        end
    end

    // held output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_pixel_reg <= '0;
            held_lv_reg    <= 1'b0;
            held_fv_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (conv_reg)
                held_pixel_reg <= res;
            if (delay_reg == '0)
            begin
                held_lv_reg <= lv_reg;
                held_fv_reg <= fv_reg;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid                = out_valid_reg;
    assign out_data.pixel_out       = held_pixel_reg;
    assign out_data.line_valid_out  = held_lv_reg;
    assign out_data.frame_valid_out = held_fv_reg;

endmodule

`default_nettype wire
